FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the Huffman encoder RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/hte_pkg.sv
// ---------------------------------------------------------------------------
// hte_pkg
// Types and constants shared by the Huffman table encoder modules.
// ---------------------------------------------------------------------------
package hte_pkg;

    localparam int DEFAULT_MAX_CODE_LEN = 16;
    localparam int DEFAULT_SYMBOL_COUNT = 256;

    // Fixed field widths of the item channels
    localparam int SYM_W      = 8;
    localparam int CODE_IN_W  = 16;
    localparam int LEN_IN_W   = 5;
    localparam int BYTE_W     = 8;
    localparam int TOTAL_W    = 32;
    localparam int PEND_W     = 7;
    localparam int PCNT_W     = 3;

    // Result queue sizing (entries hold one or two bytes)
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_ENCODE = 2'd1,
        OP_FLUSH  = 2'd2
    } op_t;

    // Lookup stage output: item after the table read
    typedef struct packed {
        logic                 vld;
        logic [1:0]           op;
        logic [LEN_IN_W-1:0]  len;
        logic [CODE_IN_W-1:0] code;
    } lookup_t;

    // One queue entry: one or two output bytes from a single item
    typedef struct packed {
        logic               two;
        logic [BYTE_W-1:0]  first;
        logic [BYTE_W-1:0]  second;
        logic [TOTAL_W-1:0] total;
    } res_t;

endpackage

FILE: rtl/hte_code_table.sv
// ---------------------------------------------------------------------------
// hte_code_table
// Code table memory with per-entry valid bits and the registered lookup stage.
// ---------------------------------------------------------------------------
module hte_code_table #(
    parameter int SYMBOL_COUNT = hte_pkg::DEFAULT_SYMBOL_COUNT,
    parameter int MAX_CODE_LEN = hte_pkg::DEFAULT_MAX_CODE_LEN
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [1:0]                    op,
    input  logic [hte_pkg::SYM_W-1:0]     symbol,
    input  logic [hte_pkg::CODE_IN_W-1:0] code_bits,
    input  logic [hte_pkg::LEN_IN_W-1:0]  code_length,
    output hte_pkg::lookup_t              lookup
);

    localparam int LEN_LIMIT = (MAX_CODE_LEN < 16) ? MAX_CODE_LEN : 16;
    localparam int LEN_W     = $clog2(LEN_LIMIT + 1);
    localparam int ADDR_W    = $clog2(SYMBOL_COUNT);
    localparam int ENTRY_W   = LEN_W + LEN_LIMIT;
    localparam logic [hte_pkg::SYM_W:0] SYM_LIMIT = (hte_pkg::SYM_W + 1)'(SYMBOL_COUNT);

    logic [ENTRY_W-1:0]      mem [SYMBOL_COUNT];
    logic [SYMBOL_COUNT-1:0] valid_reg;
    logic [ENTRY_W-1:0]      rd_data_reg;
    logic                    rd_hit_reg;
    logic                    stg_valid_reg;
    logic [1:0]              stg_op_reg;

    logic [ADDR_W-1:0]    addr;
    logic                 in_range;
    logic [LEN_W-1:0]     sat_len;
    logic [LEN_LIMIT-1:0] code_mask;
    logic [LEN_LIMIT-1:0] masked_code;
    logic                 do_load;
    logic                 do_read;

    assign addr     = symbol[ADDR_W-1:0];
    assign in_range = ({1'b0, symbol} < SYM_LIMIT);
    assign do_load  = accept && (op == hte_pkg::OP_LOAD) && in_range;
    assign do_read  = accept && (op == hte_pkg::OP_ENCODE);

    // Clamp overlong codes; drop code bits above the stored length
    always_comb
    begin
        if (code_length > hte_pkg::LEN_IN_W'(LEN_LIMIT))
        begin
            sat_len = LEN_W'(LEN_LIMIT);
        end
        else
        begin
            sat_len = code_length[LEN_W-1:0];
        end
        code_mask   = (LEN_LIMIT'(1) << sat_len) - LEN_LIMIT'(1);
        masked_code = code_bits[LEN_LIMIT-1:0] & code_mask;
    end

    always_ff @(posedge clk)
    begin
        if (do_load)
        begin
            mem[addr] <= {sat_len, masked_code};
        end
        if (do_read)
        begin
            rd_data_reg <= mem[addr];
        end
        if (accept)
        begin
            stg_op_reg <= op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            rd_hit_reg    <= 1'b0;
            stg_valid_reg <= 1'b0;
        end
        else
        begin
            stg_valid_reg <= accept;
            if (do_load)
            begin
                valid_reg[addr] <= 1'b1;
            end
            if (do_read)
            begin
                rd_hit_reg <= valid_reg[addr] && in_range;
            end
        end
    end

    // Never-loaded or out-of-range entries read as length zero
    always_comb
    begin
        lookup.vld  = stg_valid_reg;
        lookup.op   = stg_op_reg;
        lookup.len  = '0;
        lookup.code = '0;
        if (rd_hit_reg)
        begin
            lookup.len  = hte_pkg::LEN_IN_W'(rd_data_reg[ENTRY_W-1:LEN_LIMIT]);
            lookup.code = hte_pkg::CODE_IN_W'(rd_data_reg[LEN_LIMIT-1:0]);
        end
    end

endmodule

FILE: rtl/hte_bit_packer.sv
// ---------------------------------------------------------------------------
// hte_bit_packer
// Pending-bit accumulator, byte extraction and saturating bit total.
// ---------------------------------------------------------------------------
module hte_bit_packer (
    input  logic             clk,
    input  logic             rst_n,
    input  hte_pkg::lookup_t lookup,
    output logic             push,
    output hte_pkg::res_t    res
);

    localparam int ACC_W = hte_pkg::PEND_W + hte_pkg::CODE_IN_W;

    logic [hte_pkg::PEND_W-1:0]  pend_bits_reg, pend_bits_next;
    logic [hte_pkg::PCNT_W-1:0]  pend_cnt_reg,  pend_cnt_next;
    logic [hte_pkg::TOTAL_W-1:0] total_reg,     total_next;

    logic [ACC_W-1:0]              acc;
    logic [hte_pkg::LEN_IN_W-1:0]  cnt;
    logic [hte_pkg::LEN_IN_W-1:0]  sh0;
    logic [hte_pkg::LEN_IN_W-1:0]  sh1;
    logic [hte_pkg::TOTAL_W:0]     sum;
    logic [hte_pkg::TOTAL_W-1:0]   sat_total;
    logic [hte_pkg::PCNT_W-1:0]    new_cnt;
    logic [hte_pkg::PEND_W-1:0]    new_mask;

    always_comb
    begin
        acc = (ACC_W'(pend_bits_reg) << lookup.len) | ACC_W'(lookup.code);
        cnt = hte_pkg::LEN_IN_W'(pend_cnt_reg) + lookup.len;
        sh0 = cnt - hte_pkg::LEN_IN_W'(8);
        sh1 = cnt - hte_pkg::LEN_IN_W'(16);
        sum = {1'b0, total_reg} + (hte_pkg::TOTAL_W + 1)'(lookup.len);
        sat_total = sum[hte_pkg::TOTAL_W] ? '1 : sum[hte_pkg::TOTAL_W-1:0];
        new_cnt  = cnt[hte_pkg::PCNT_W-1:0];
        new_mask = (hte_pkg::PEND_W'(1) << new_cnt) - hte_pkg::PEND_W'(1);
    end

    always_comb
    begin
        pend_bits_next = pend_bits_reg;
        pend_cnt_next  = pend_cnt_reg;
        total_next     = total_reg;
        push           = 1'b0;
        res.two        = 1'b0;
        res.first      = hte_pkg::BYTE_W'(acc >> sh0);
        res.second     = hte_pkg::BYTE_W'(acc >> sh1);
        res.total      = sat_total;
        if (lookup.vld)
        begin
            case (lookup.op)
                hte_pkg::OP_ENCODE:
                begin
                    if (lookup.len != '0)
                    begin
                        total_next     = sat_total;
                        pend_cnt_next  = new_cnt;
                        pend_bits_next = hte_pkg::PEND_W'(acc) & new_mask;
                        push           = (cnt >= hte_pkg::LEN_IN_W'(8));
                        res.two        = (cnt >= hte_pkg::LEN_IN_W'(16));
                    end
                end
                hte_pkg::OP_FLUSH:
                begin
                    // leftover bits go out right-aligned; total unchanged
                    res.first = hte_pkg::BYTE_W'(pend_bits_reg);
                    res.total = total_reg;
                    if (pend_cnt_reg != '0)
                    begin
                        push           = 1'b1;
                        pend_bits_next = '0;
                        pend_cnt_next  = '0;
                    end
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_bits_reg <= '0;
            pend_cnt_reg  <= '0;
            total_reg     <= '0;
        end
        else
        begin
            pend_bits_reg <= pend_bits_next;
            pend_cnt_reg  <= pend_cnt_next;
            total_reg     <= total_next;
        end
    end

endmodule

FILE: rtl/hte_out_queue.sv
// ---------------------------------------------------------------------------
// hte_out_queue
// Small result queue; an entry with two bytes is sent over two items.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hte_out_queue (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  hte_pkg::res_t                  res,
    output logic [hte_pkg::QCNT_W-1:0]     count,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [hte_pkg::BYTE_W-1:0]     out_byte,
    output logic                           out_last,
    output logic [hte_pkg::TOTAL_W-1:0]    out_total
);

    hte_pkg::res_t q [hte_pkg::QUEUE_DEPTH];

    logic [hte_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [hte_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [hte_pkg::QCNT_W-1:0] count_reg,  count_next;
    logic                       half_reg,   half_next;

    hte_pkg::res_t head;
    logic          xfer;
    logic          pop_entry;

    assign head      = q[rd_ptr_reg];
    assign m_tvalid  = (count_reg != '0);
    assign xfer      = m_tvalid && m_tready;
    assign pop_entry = xfer && (!head.two || half_reg);
    assign out_byte  = half_reg ? head.second : head.first;
    assign out_last  = !head.two || half_reg;
    assign out_total = head.total;
    assign count     = count_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + hte_pkg::QPTR_W'(push);
        rd_ptr_next = rd_ptr_reg + hte_pkg::QPTR_W'(pop_entry);
        count_next  = count_reg + hte_pkg::QCNT_W'(push) - hte_pkg::QCNT_W'(pop_entry);
        half_next   = half_reg;
        if (xfer)
        begin
            half_next = head.two && !half_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q[wr_ptr_reg] <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            half_reg   <= 1'b0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            half_reg   <= half_next;
        end
    end

    `ASSERT_IMPLY(a_no_overflow, clk, rst_n, push, (count_reg < hte_pkg::QCNT_W'(hte_pkg::QUEUE_DEPTH)), "result queue overflow")
    `ASSERT_IMPLY(a_half_on_pair, clk, rst_n, half_reg, ((count_reg != '0) && head.two), "second half without a two-byte entry")
    `ASSERT_NEXT(a_half_clears, clk, rst_n, (xfer && half_reg), !half_reg, "second byte sent but half flag stuck")

endmodule

FILE: rtl/huffman_table_encoder_packer.sv
// ---------------------------------------------------------------------------
// huffman_table_encoder_packer
// Table-driven Huffman encoder with an MSB-first byte packer.
// ---------------------------------------------------------------------------
// The block takes one item per clock while s_tready is high: a load writes
// a code table entry, an encode appends its symbol's code to the pending
// bits, a flush sends the 1 to 7 leftover bits as one right-aligned byte.
// Operation rides on s_tuser. An item is looked up in the code table memory
// in the cycle it is accepted (synchronous read), packed in the next cycle
// and its bytes queued; the first byte can show on the master side once its
// queue entry is registered. Loads and encodes follow each other back to
// back with no bubble: the table write of a load lands at its accept edge,
// before any later read. An encode that completes two bytes takes two output
// items, one per byte; input runs at one item per cycle until the queued
// entries plus the lookup stage item fill the four-entry queue, then at one
// byte per cycle while m_tready is high. The table is cleared at reset by its
// per-entry valid bits, so no clearing pass is needed; input is taken at once.
// ---------------------------------------------------------------------------
module huffman_table_encoder_packer #(
    parameter int MAX_CODE_LEN = hte_pkg::DEFAULT_MAX_CODE_LEN,
    parameter int SYMBOL_COUNT = hte_pkg::DEFAULT_SYMBOL_COUNT
) (
    input  logic        clk,
    input  logic        rst_n,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // symbol[7:0], code_bits[23:8], code_length[28:24], zero
    input  logic [1:0]  s_tuser,   // operation[1:0]
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // packed_byte[7:0], total_bits[39:8]
    output logic        m_tlast    // last byte caused by the input item
);

    logic                          s_accept;
    hte_pkg::lookup_t              lookup;
    logic                          push;
    hte_pkg::res_t                 res;
    logic [hte_pkg::QCNT_W-1:0]    q_count;
    logic [hte_pkg::QCNT_W-1:0]    occupancy;
    logic [hte_pkg::BYTE_W-1:0]    out_byte;
    logic [hte_pkg::TOTAL_W-1:0]   out_total;

    // Queue slots held by what is queued plus the item now in the lookup stage;
    // one more slot must be free for a new item.
    assign occupancy = q_count + hte_pkg::QCNT_W'(lookup.vld);
    assign s_tready  = (occupancy < hte_pkg::QCNT_W'(hte_pkg::QUEUE_DEPTH));
    assign s_accept  = s_tvalid && s_tready;

    hte_code_table #(
        .SYMBOL_COUNT (SYMBOL_COUNT),
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_table (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (s_accept),
        .op          (s_tuser),
        .symbol      (s_tdata[7:0]),
        .code_bits   (s_tdata[23:8]),
        .code_length (s_tdata[28:24]),
        .lookup      (lookup)
    );

    // Packer state updates once per item; never stalls (queue space reserved)
    hte_bit_packer u_packer (
        .clk    (clk),
        .rst_n  (rst_n),
        .lookup (lookup),
        .push   (push),
        .res    (res)
    );

    hte_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .res       (res),
        .count     (q_count),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .out_byte  (out_byte),
        .out_last  (m_tlast),
        .out_total (out_total)
    );

    assign m_tdata = {out_total, out_byte};

endmodule
